// ===== design/sst_pkg.sv =====
// ---------------------------------------------------------------------------
// Sparse set table package
// Command and status codes and the sequencer state type shared by the design.
// ---------------------------------------------------------------------------
package sst_pkg;

   typedef logic [1:0] command_type;
   typedef logic [1:0] status_type;

   localparam command_type CMD_ENSURE = 2'd0;
   localparam command_type CMD_LOOKUP = 2'd1;
   localparam command_type CMD_REMOVE = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_MOVE,
      ST_UNLINK,
      ST_RESULT
   } state_type;

endpackage

// ===== design/sst_ram.sv =====
// ---------------------------------------------------------------------------
// Sparse set table RAM
// Generic single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/sparse_set_table.sv =====
// An ignored command or an out-of-range key goes from accept straight to ST_RESULT; ensure,
// lookup and a remove that misses pass ST_LOOKUP, a remove that hits ST_LOOKUP, ST_MOVE, ST_UNLINK.
// One item at a time: the next word is taken once the result is in the output register.
// Reset is synchronous; after it the sparse map is cleared one entry a cycle, all KEY_SPACE
// entries (1024 by default), while req_stall stays high.
// ---------------------------------------------------------------------------
// Sparse set table
// Sparse key-to-slot map and packed dense key list with ensure, lookup and
// swap-with-last remove, sequenced over two single-port RAMs.
// ---------------------------------------------------------------------------
module sparse_set_table #(
   parameter int KEY_SPACE = 1024,
   parameter int CAPACITY  = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sst_pkg::command_type                req_command,
   input  logic [$clog2(KEY_SPACE)-1:0]        req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sst_pkg::status_type                 rsp_status,
   output logic                                rsp_hit,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_slot,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_moved_from,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_live_count
);
   import sst_pkg::*;

   localparam int KEY_W  = $clog2(KEY_SPACE);
   localparam int SLOT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   command_type       cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] count_ff;
   logic [KEY_W-1:0]  clr_ff;

   status_type        res_status_ff;
   logic              res_hit_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic [SLOT_W-1:0] res_moved_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic              rsp_hit_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [SLOT_W-1:0] rsp_moved_ff;
   logic [SLOT_W-1:0] rsp_count_ff;

   logic              sparse_en, sparse_we;
   logic [KEY_W-1:0]  sparse_addr;
   logic [SLOT_W-1:0] sparse_wdata, sparse_rdata;
   logic              dense_en, dense_we;
   logic [SLOT_W-1:0] dense_addr;
   logic [KEY_W-1:0]  dense_wdata, dense_rdata;

   logic              req_take;
   logic              req_cmd_ok;
   logic              req_in_range;
   logic              out_free;
   logic [SLOT_W-1:0] found_slot;
   logic              found;
   logic              table_full;
   logic [SLOT_W-1:0] next_slot;
   logic              last_in_range;

   sst_ram #(.WIDTH(SLOT_W), .DEPTH(KEY_SPACE)) u_sparse (
      .clock (clock),
      .en    (sparse_en),
      .we    (sparse_we),
      .addr  (sparse_addr),
      .wdata (sparse_wdata),
      .rdata (sparse_rdata)
   );

   sst_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY + 1)) u_dense (
      .clock (clock),
      .en    (dense_en),
      .we    (dense_we),
      .addr  (dense_addr),
      .wdata (dense_wdata),
      .rdata (dense_rdata)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign req_cmd_ok   = req_command inside {CMD_ENSURE, CMD_LOOKUP, CMD_REMOVE};
   assign req_in_range = (KEY_W + 1)'(req_key) < (KEY_W + 1)'(KEY_SPACE);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Drop a stored slot that points past the live list.
   assign found_slot    = (sparse_rdata > SLOT_W'(CAPACITY) || sparse_rdata > count_ff) ?
                          '0 : sparse_rdata;
   assign found         = (found_slot != '0);
   assign table_full    = (count_ff == SLOT_W'(CAPACITY));
   assign next_slot     = count_ff + 1'b1;
   assign last_in_range = (KEY_W + 1)'(dense_rdata) < (KEY_W + 1)'(KEY_SPACE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == KEY_W'(KEY_SPACE - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_cmd_ok && req_in_range) ? ST_LOOKUP : ST_RESULT;
            end
         end
         ST_LOOKUP: begin
            state_in = (cmd_ff == CMD_REMOVE && found) ? ST_MOVE : ST_RESULT;
         end
         ST_MOVE:   state_in = ST_UNLINK;
         ST_UNLINK: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Memory accesses
   always_comb begin
      sparse_en    = 1'b0;
      sparse_we    = 1'b0;
      sparse_addr  = key_ff;
      sparse_wdata = '0;
      dense_en     = 1'b0;
      dense_we     = 1'b0;
      dense_addr   = count_ff;
      dense_wdata  = key_ff;
      case (state_ff)
         ST_CLEAR: begin
            sparse_en   = 1'b1;
            sparse_we   = 1'b1;
            sparse_addr = clr_ff;
         end
         ST_IDLE: begin
            sparse_en   = req_take;
            sparse_addr = req_key;
         end
         ST_LOOKUP: begin
            if (cmd_ff == CMD_ENSURE && !found && !table_full) begin
               // append the key at the end of the dense list
               sparse_en    = 1'b1;
               sparse_we    = 1'b1;
               sparse_wdata = next_slot;
               dense_en     = 1'b1;
               dense_we     = 1'b1;
               dense_addr   = next_slot;
            end else if (cmd_ff == CMD_REMOVE && found) begin
               // fetch the key held in the last slot
               dense_en = 1'b1;
            end
         end
         ST_MOVE: begin
            // point the last key at the freed slot and move it there
            sparse_en    = last_in_range;
            sparse_we    = 1'b1;
            sparse_addr  = dense_rdata;
            sparse_wdata = slot_ff;
            dense_en     = 1'b1;
            dense_we     = 1'b1;
            dense_addr   = slot_ff;
            dense_wdata  = dense_rdata;
         end
         ST_UNLINK: begin
            sparse_en = 1'b1;
            sparse_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_LOOKUP && cmd_ff == CMD_ENSURE && !found && !table_full) begin
            count_ff <= next_slot;
         end
         if (state_ff == ST_UNLINK) count_ff <= count_ff - 1'b1;
         if (state_ff == ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff        <= req_command;
         key_ff        <= req_key;
         res_status_ff <= (req_cmd_ok && !req_in_range) ? STATUS_RANGE : STATUS_OK;
         res_hit_ff    <= 1'b0;
         res_slot_ff   <= '0;
         res_moved_ff  <= '0;
      end
      if (state_ff == ST_LOOKUP) begin
         slot_ff <= found_slot;
         case (cmd_ff)
            CMD_ENSURE: begin
               if (found) begin
                  res_slot_ff <= found_slot;
               end else if (table_full) begin
                  res_status_ff <= STATUS_FULL;
               end else begin
                  res_hit_ff  <= 1'b1;
                  res_slot_ff <= next_slot;
               end
            end
            CMD_LOOKUP, CMD_REMOVE: begin
               if (found) begin
                  res_hit_ff  <= 1'b1;
                  res_slot_ff <= found_slot;
                  if (cmd_ff == CMD_REMOVE) res_moved_ff <= count_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (state_ff == ST_RESULT && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_hit_ff    <= res_hit_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_moved_ff  <= res_moved_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_moved_from = rsp_moved_ff;
   assign rsp_live_count = rsp_count_ff;

endmodule

// ===== tb/sv/sst_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse set table checker
// Watches the request and response channels, keeps its own sparse map and
// packed dense list, and compares every response word with the prediction.
// ---------------------------------------------------------------------------
module sst_checker #(
   parameter int KEY_SPACE = 1024,
   parameter int CAPACITY  = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  sst_pkg::command_type                req_command,
   input  logic [$clog2(KEY_SPACE)-1:0]        req_key,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  sst_pkg::status_type                 rsp_status,
   input  logic                                rsp_hit,
   input  logic [$clog2(CAPACITY+1)-1:0]       rsp_slot,
   input  logic [$clog2(CAPACITY+1)-1:0]       rsp_moved_from,
   input  logic [$clog2(CAPACITY+1)-1:0]       rsp_live_count,
   output int                                  error_count,
   output int                                  pending_count,
   output int                                  checked_count
);
   import sst_pkg::*;

   localparam int KW = $clog2(KEY_SPACE);
   localparam int SW = $clog2(CAPACITY + 1);

   typedef struct packed {
      status_type    status;
      logic          hit;
      logic [SW-1:0] slot;
      logic [SW-1:0] moved_from;
      logic [SW-1:0] live_count;
   } outcome_type;

   logic [SW-1:0] slot_of_key [KEY_SPACE];
   logic [KW-1:0] key_in_slot [CAPACITY+1];
   logic [SW-1:0] live_keys;
   outcome_type   outcome_q [$];
   int            mismatches    = 0;
   int            words_checked = 0;

   function automatic outcome_type predict_outcome(input command_type cmd,
                                                   input logic [KW-1:0] key);
      outcome_type   o;
      logic [SW-1:0] s;
      logic [SW-1:0] last;
      logic [KW-1:0] last_key;
      o = '0;
      if (cmd == CMD_ENSURE || cmd == CMD_LOOKUP || cmd == CMD_REMOVE) begin
         if (int'(key) >= KEY_SPACE) begin
            o.status = STATUS_RANGE;
         end else begin
            s = slot_of_key[key];
            case (cmd)
               CMD_ENSURE: begin
                  if (s != '0) begin
                     o.slot = s;
                  end else if (int'(live_keys) >= CAPACITY) begin
                     o.status = STATUS_FULL;
                  end else begin
                     live_keys = live_keys + 1'b1;
                     key_in_slot[live_keys] = key;
                     slot_of_key[key] = live_keys;
                     o.hit  = 1'b1;
                     o.slot = live_keys;
                  end
               end
               CMD_LOOKUP: begin
                  if (s != '0) begin
                     o.hit  = 1'b1;
                     o.slot = s;
                  end
               end
               default: begin
                  if (s != '0) begin
                     // move the last dense entry into the freed slot
                     last     = live_keys;
                     last_key = key_in_slot[last];
                     slot_of_key[last_key] = s;
                     key_in_slot[s] = last_key;
                     slot_of_key[key] = '0;
                     live_keys = live_keys - 1'b1;
                     o.hit        = 1'b1;
                     o.slot       = s;
                     o.moved_from = last;
                  end
               end
            endcase
         end
      end
      o.live_count = live_keys;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [SW-1:0] want,
                              input logic [SW-1:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < KEY_SPACE; i++) slot_of_key[i] = '0;
         live_keys = '0;
         outcome_q.delete();
      end else begin
         // retire the response first: it always belongs to an earlier word
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("response word with nothing expected: status %0d slot %0d",
                      rsp_status, rsp_slot);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               check_field("status", SW'(want.status), SW'(rsp_status));
               check_field("hit", SW'(want.hit), SW'(rsp_hit));
               check_field("slot", want.slot, rsp_slot);
               check_field("moved_from", want.moved_from, rsp_moved_from);
               check_field("live_count", want.live_count, rsp_live_count);
               words_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            outcome_q.push_back(predict_outcome(req_command, req_key));
         end
      end
      error_count   <= mismatches;
      pending_count <= outcome_q.size();
      checked_count <= words_checked;
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse set table testbench
// Drives ensure, lookup, remove and ignored words under changing idle and stall mixes,
// including a fill past capacity, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb;
   import sst_pkg::*;

   localparam int KEY_SPACE   = 1024;
   localparam int CAPACITY    = 256;
   localparam int KW          = $clog2(KEY_SPACE);
   localparam int SW          = $clog2(CAPACITY + 1);
   localparam int POOL_STRIDE = 33;
   localparam int FILL_WORDS  = 300;
   localparam int MAX_GAP     = 30;

   localparam command_type CMD_IGNORED = 2'd3;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   command_type   req_command = CMD_ENSURE;
   logic [KW-1:0] req_key     = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   status_type    rsp_status;
   logic          rsp_hit;
   logic [SW-1:0] rsp_slot;
   logic [SW-1:0] rsp_moved_from;
   logic [SW-1:0] rsp_live_count;

   int error_count;
   int pending_count;
   int checked_count;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int words_sent = 0;

   sparse_set_table #(
      .KEY_SPACE (KEY_SPACE),
      .CAPACITY  (CAPACITY)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_hit        (rsp_hit),
      .rsp_slot       (rsp_slot),
      .rsp_moved_from (rsp_moved_from),
      .rsp_live_count (rsp_live_count)
   );

   sst_checker #(
      .KEY_SPACE (KEY_SPACE),
      .CAPACITY  (CAPACITY)
   ) u_sst_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_hit        (rsp_hit),
      .rsp_slot       (rsp_slot),
      .rsp_moved_from (rsp_moved_from),
      .rsp_live_count (rsp_live_count),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic set_mix(input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   task automatic send_word(input command_type cmd, input logic [KW-1:0] key);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_key     <= KW'($urandom);
         req_command <= command_type'($urandom_range(3));
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // drop valid and hold until every expected word is back
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic random_words(input int count);
      int          done;
      int          r;
      command_type cmd;
      logic [KW-1:0] key;
      done = 0;
      while (done < count) begin
         r = $urandom_range(99);
         if (r < 45) cmd = CMD_ENSURE;
         else if (r < 70) cmd = CMD_LOOKUP;
         else if (r < 96) cmd = CMD_REMOVE;
         else cmd = CMD_IGNORED;
         // favor a small key pool so removes and lookups find their keys
         if ($urandom_range(99) < 70) key = KW'($urandom_range(31) * POOL_STRIDE);
         else key = KW'($urandom_range(KEY_SPACE - 1));
         send_word(cmd, key);
         if (cmd != CMD_IGNORED) done++;
      end
   endtask

   initial begin
      int base;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: extreme keys, every command, present and absent keys
      set_mix(0, 0);
      send_word(CMD_ENSURE, 10'd0);
      send_word(CMD_ENSURE, 10'd1023);
      send_word(CMD_ENSURE, 10'd0);
      send_word(CMD_LOOKUP, 10'd1023);
      send_word(CMD_LOOKUP, 10'd341);
      send_word(CMD_REMOVE, 10'd682);
      send_word(CMD_REMOVE, 10'd1023);
      send_word(CMD_ENSURE, 10'd682);
      send_word(CMD_ENSURE, 10'd341);
      send_word(CMD_REMOVE, 10'd0);
      send_word(CMD_LOOKUP, 10'd341);
      send_word(CMD_LOOKUP, 10'd682);
      send_word(CMD_IGNORED, 10'd1023);
      send_word(CMD_IGNORED, 10'd0);
      send_word(CMD_REMOVE, 10'd341);
      send_word(CMD_REMOVE, 10'd682);
      send_word(CMD_LOOKUP, 10'd0);
      send_word(CMD_ENSURE, 10'd1023);
      send_word(CMD_REMOVE, 10'd1023);
      hold_until_drained();

      random_words(60);

      set_mix(71, 0);
      random_words(60);
      hold_until_drained();

      set_mix(0, 71);
      random_words(60);

      // fill past capacity, then sweep out half of the fill keys
      set_mix(13, 13);
      base = $urandom_range(KEY_SPACE - 1);
      for (int i = 0; i < FILL_WORDS; i++) begin
         send_word(CMD_ENSURE, KW'((base + i * 7) % KEY_SPACE));
      end
      send_word(CMD_ENSURE, KW'(base));
      send_word(CMD_LOOKUP, KW'(base));
      for (int i = 0; i < FILL_WORDS; i += 2) begin
         send_word(CMD_REMOVE, KW'((base + i * 7) % KEY_SPACE));
         if (i % 8 == 0) send_word(CMD_LOOKUP, KW'((base + (i + 1) * 7) % KEY_SPACE));
      end

      set_mix(0, 0);
      random_words(60);

      hold_until_drained();
      repeat (10) @(negedge clock);
      $display("Run covered %0d request words and %0d checked responses", words_sent,
               checked_count);
      $display("Mix: extreme keys, all commands, fill past capacity, swap-with-last removes");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
